/* sv/rfa_pkg.sv */
// rfa_pkg: shared types and codes for the rational fraction arithmetic unit
`default_nettype none
package rfa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_RED = 4'd4,
        CMD_CMP = 4'd5,
        CMD_POS = 4'd6,
        CMD_NEG = 4'd7,
        CMD_ZER = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_sel_den;
        logic div_step;
        logic finish;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_reduce;
        logic red_trivial;
        logic gcd_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

/* sv/rfa_datapath.sv */
// rfa_datapath: operand registers, products, gcd and restoring divider
`default_nettype none
module rfa_datapath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rfa_pkg::ctrl_t ctrl,
    output rfa_pkg::stat_t      stat,
    input  wire logic [3:0]     in_cmd,
    input  wire logic [127:0]   in_ops,
    output logic [63:0]         res_num,
    output logic [63:0]         res_den,
    output logic [1:0]          order,
    output logic                test_flag
);
    localparam int W = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [3:0]          cmd_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [2*W-1:0] p1_reg, p2_reg, p3_reg;
    logic [1:0]          mul_cnt_reg;
    logic [W-1:0]        gx_reg, gy_reg;
    logic [CW-1:0]       gk_reg;
    logic [W-1:0]        dq_reg, dr_reg, dn_reg;
    logic [CW-1:0]       dcnt_reg;
    logic [W-1:0]        qn_reg;
    logic [63:0]         rn_reg, rd_reg;
    logic [1:0]          ord_reg;
    logic                flag_reg;

    logic [W-1:0] mag_an, mag_ad;
    logic         a_neg_den, b_neg_den;
    logic signed [W-1:0] m_x, m_y;
    logic signed [2*W-1:0] m_p;
    logic [W:0]   rem_try;

    assign mag_an = an_reg[W-1] ? (~an_reg + 1'b1) : an_reg;
    assign mag_ad = ad_reg[W-1] ? (~ad_reg + 1'b1) : ad_reg;
    assign a_neg_den = ad_reg[W-1];
    assign b_neg_den = bd_reg[W-1];

    // one shared multiplier, three passes selected by the step count
    always_comb
    begin
        m_x = an_reg;
        m_y = bd_reg;
        case (mul_cnt_reg)
            2'd0:
            begin
                m_x = an_reg;
                m_y = (cmd_reg == rfa_pkg::CMD_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                m_x = (cmd_reg == rfa_pkg::CMD_DIV) ? ad_reg : bn_reg;
                m_y = (cmd_reg == rfa_pkg::CMD_DIV) ? bn_reg : ad_reg;
            end
            default:
            begin
                m_x = ad_reg;
                m_y = bd_reg;
            end
        endcase
        m_p = m_x * m_y;
    end

    // trial subtract of the shifted remainder against the gcd
    assign rem_try = {dr_reg, dn_reg[W-1]} - {1'b0, gx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
            dcnt_reg    <= '0;
        end
        else
        begin
            if (ctrl.load)
                mul_cnt_reg <= '0;
            else if (ctrl.mul_step)
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            if (ctrl.div_start)
                dcnt_reg <= CW'(W);
            else if (ctrl.div_step)
                dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= in_cmd;
            an_reg  <= in_ops[W-1:0];
            ad_reg  <= in_ops[32+W-1:32];
            bn_reg  <= in_ops[64+W-1:64];
            bd_reg  <= in_ops[96+W-1:96];
        end
        if (ctrl.mul_step)
        begin
            case (mul_cnt_reg)
                2'd0:    p1_reg <= m_p;
                2'd1:    p2_reg <= m_p;
                default: p3_reg <= m_p;
            endcase
        end
        // binary gcd: strip common twos, reduce odd pairs, then put the twos back
        if (ctrl.gcd_start)
        begin
            gx_reg <= mag_an;
            gy_reg <= mag_ad;
            gk_reg <= '0;
        end
        else if (ctrl.gcd_step)
        begin
            if (gy_reg == '0)
            begin
                gx_reg <= {gx_reg[W-2:0], 1'b0};
                gk_reg <= gk_reg - 1'b1;
            end
            else if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= {1'b0, gx_reg[W-1:1]};
                gy_reg <= {1'b0, gy_reg[W-1:1]};
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gx_reg[0])
                gx_reg <= {1'b0, gx_reg[W-1:1]};
            else if (!gy_reg[0])
                gy_reg <= {1'b0, gy_reg[W-1:1]};
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gy_reg;
                gy_reg <= gx_reg - gy_reg;
            end
            else
                gy_reg <= gy_reg - gx_reg;
        end
        // restoring divide of a magnitude by the gcd held in gx
        if (ctrl.div_start)
        begin
            dn_reg <= ctrl.div_sel_den ? mag_ad : mag_an;
            dr_reg <= '0;
            dq_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            dn_reg <= {dn_reg[W-2:0], 1'b0};
            if (!rem_try[W])
            begin
                dr_reg <= rem_try[W-1:0];
                dq_reg <= {dq_reg[W-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[W-2:0], dn_reg[W-1]};
                dq_reg <= {dq_reg[W-2:0], 1'b0};
            end
        end
        // last numerator step coincides with the start of the denominator divide
        if (ctrl.div_step && ctrl.div_start)
            qn_reg <= (!rem_try[W]) ? {dq_reg[W-2:0], 1'b1}
                                    : {dq_reg[W-2:0], 1'b0};
        if (ctrl.finish)
            begin
            rn_reg   <= '0;
            rd_reg   <= '0;
            ord_reg  <= '0;
            flag_reg <= 1'b0;
            case (cmd_reg)
                rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB:
                begin
                    if (ad_reg == bd_reg)
                    begin
                        rn_reg <= (cmd_reg == rfa_pkg::CMD_ADD)
                                  ? 64'(an_reg) + 64'(bn_reg) : 64'(an_reg) - 64'(bn_reg);
                        rd_reg <= 64'(ad_reg);
                    end
                    else
                    begin
                        rn_reg <= (cmd_reg == rfa_pkg::CMD_ADD)
                                  ? 64'(p1_reg) + 64'(p2_reg) : 64'(p1_reg) - 64'(p2_reg);
                        rd_reg <= 64'(p3_reg);
                    end
                end
                rfa_pkg::CMD_MUL:
                begin
                    rn_reg <= 64'(p1_reg);
                    rd_reg <= 64'(p3_reg);
                end
                rfa_pkg::CMD_DIV:
                begin
                    if (bn_reg != '0)
                    begin
                        rn_reg <= 64'(p1_reg);
                        rd_reg <= 64'(p2_reg);
                    end
                end
                rfa_pkg::CMD_RED:
                begin
                    if (an_reg == '0)
                    begin
                        rn_reg <= 64'(an_reg);
                        rd_reg <= 64'(ad_reg);
                    end
                    else if (an_reg[W-1] != a_neg_den)
                    begin
                        rn_reg <= 64'd0 - 64'(qn_reg);
                        rd_reg <= 64'(dq_reg);
                    end
                    else
                    begin
                        rn_reg <= 64'(qn_reg);
                        rd_reg <= 64'(dq_reg);
                    end
                end
                rfa_pkg::CMD_CMP:
                begin
                    if (p1_reg == p2_reg)
                        ord_reg <= 2'b00;
                    else if ((p1_reg > p2_reg) != (a_neg_den != b_neg_den))
                        ord_reg <= 2'b01;
                    else
                        ord_reg <= 2'b11;
                end
                rfa_pkg::CMD_POS:
                    flag_reg <= (!an_reg[W-1] && an_reg != '0 && !a_neg_den)
                                || (an_reg[W-1] && a_neg_den);
                rfa_pkg::CMD_NEG:
                    flag_reg <= (an_reg[W-1] && !a_neg_den)
                                || (!an_reg[W-1] && an_reg != '0 && a_neg_den);
                rfa_pkg::CMD_ZER:
                    flag_reg <= (an_reg == '0);
                default: ;
            endcase
        end
    end

    assign stat.is_reduce   = (cmd_reg == rfa_pkg::CMD_RED);
    assign stat.red_trivial = (an_reg == '0);
    assign stat.gcd_done    = (gy_reg == '0) && (gk_reg == '0);
    assign stat.div_done    = (dcnt_reg == CW'(1));

    assign res_num   = rn_reg;
    assign res_den   = rd_reg;
    assign order     = ord_reg;
    assign test_flag = flag_reg;

endmodule
`default_nettype wire

/* sv/rfa_ctrl.sv */
// rfa_ctrl: sequencing state machine and stream handshake
`default_nettype none
module rfa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire rfa_pkg::stat_t stat,
    output rfa_pkg::ctrl_t      ctrl
);
    rfa_pkg::state_t state_reg, state_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic       vld_reg, vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfa_pkg::ST_IDLE;
            mcnt_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            vld_reg   <= vld_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        vld_next   = vld_reg;
        if (vld_reg && out_ready)
            vld_next = 1'b0;
        case (state_reg)
            rfa_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = rfa_pkg::ST_MUL;
                    mcnt_next  = '0;
                end
            rfa_pkg::ST_MUL:
            begin
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2)
                    state_next = (stat.is_reduce && !stat.red_trivial)
                                 ? rfa_pkg::ST_GCD : rfa_pkg::ST_FIN;
            end
            rfa_pkg::ST_GCD:
                if (stat.gcd_done)
                    state_next = rfa_pkg::ST_DIVN;
            rfa_pkg::ST_DIVN:
                if (stat.div_done)
                    state_next = rfa_pkg::ST_DIVD;
            rfa_pkg::ST_DIVD:
                if (stat.div_done)
                    state_next = rfa_pkg::ST_FIN;
            rfa_pkg::ST_FIN:
                if (!vld_reg || out_ready)
                    state_next = rfa_pkg::ST_OUT;
            rfa_pkg::ST_OUT:
                if (!vld_reg || out_ready)
                begin
                    vld_next   = 1'b1;
                    state_next = rfa_pkg::ST_IDLE;
                end
            default:
                state_next = rfa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        case (state_reg)
            rfa_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            rfa_pkg::ST_MUL:
            begin
                ctrl.mul_step  = 1'b1;
                ctrl.gcd_start = (mcnt_reg == 2'd2);
            end
            rfa_pkg::ST_GCD:
            begin
                ctrl.gcd_step  = !stat.gcd_done;
                ctrl.div_start = stat.gcd_done;
            end
            rfa_pkg::ST_DIVN:
            begin
                ctrl.div_step    = 1'b1;
                ctrl.div_start   = stat.div_done;
                ctrl.div_sel_den = stat.div_done;
            end
            rfa_pkg::ST_DIVD:
            begin
                ctrl.div_step    = 1'b1;
                ctrl.div_sel_den = 1'b1;
            end
            // result register is written only once the previous word has left
            rfa_pkg::ST_FIN:
                ctrl.finish = !vld_reg || out_ready;
            default: ;
        endcase
    end

    assign out_valid = vld_reg;

endmodule
`default_nettype wire

/* sv/rational_fraction_alu_top.sv */
// rational_fraction_alu_top: stream-facing top of the fraction arithmetic unit
// One word in, one word out. Add, sub, mul, div, compare and the sign tests take
// three passes through one shared signed multiplier. Reduce adds a binary gcd and
// two bit-serial divides. The result sits in an output register, so a new word
// is taken while the previous result is still waiting; a finished result is held
// back until the previous one has been taken.
`default_nettype none
module rational_fraction_alu_top #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100]
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num[63:0], res_den[127:64], order[129:128], test_flag[130]
    output logic [135:0]      m_axis_tdata
);
    rfa_pkg::ctrl_t ctrl;
    rfa_pkg::stat_t stat;
    logic [63:0] res_num, res_den;
    logic [1:0]  order;
    logic        test_flag;

    // sequencing
    rfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // arithmetic
    rfa_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_cmd    (s_axis_tdata[3:0]),
        .in_ops    (s_axis_tdata[131:4]),
        .res_num   (res_num),
        .res_den   (res_den),
        .order     (order),
        .test_flag (test_flag)
    );

    assign m_axis_tdata = {5'd0, test_flag, order, res_den, res_num};

endmodule
`default_nettype wire
